/* rtl/core/sif_pkg.sv */
`default_nettype none

package sif_pkg;

	localparam int TAPS        = 29;
	localparam int FACTOR_A    = 14;
	localparam int FACTOR_B    = 8;
	localparam int SPACING     = FACTOR_A * FACTOR_B;
	localparam int DEPTH       = (TAPS - 1) * SPACING + 1;
	localparam int COEF_COUNT  = 29;
	localparam int FRAC_BITS   = 17;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 18;
	localparam int COEF_IDX_W  = 6;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int ACC_W       = 40;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int FILL_W      = $clog2(DEPTH + 1);
	localparam int BACK_W      = $clog2(TAPS * SPACING + 1);
	localparam int TAP_W       = $clog2(TAPS);

	typedef struct packed {
		logic             accept;
		logic             rd_en;
		logic [TAP_W-1:0] tap;
		logic             out_load;
	} sif_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} sif_status_t;

	// q0.17 symmetric set, taps beyond the set read as zero
	function automatic logic signed [COEF_W-1:0] coef_lookup(input logic [COEF_IDX_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		case (k)
			6'd0:    c = -18'sd33;
			6'd1:    c = -18'sd743;
			6'd2:    c = -18'sd1957;
			6'd3:    c = -18'sd2893;
			6'd4:    c = -18'sd2183;
			6'd5:    c = 18'sd566;
			6'd6:    c = 18'sd3573;
			6'd7:    c = 18'sd3678;
			6'd8:    c = -18'sd667;
			6'd9:    c = -18'sd6672;
			6'd10:   c = -18'sd7950;
			6'd11:   c = 18'sd705;
			6'd12:   c = 18'sd18042;
			6'd13:   c = 18'sd35585;
			6'd14:   c = 18'sd42977;
			6'd15:   c = 18'sd35585;
			6'd16:   c = 18'sd18042;
			6'd17:   c = 18'sd705;
			6'd18:   c = -18'sd7950;
			6'd19:   c = -18'sd6672;
			6'd20:   c = -18'sd667;
			6'd21:   c = 18'sd3678;
			6'd22:   c = 18'sd3573;
			6'd23:   c = 18'sd566;
			6'd24:   c = -18'sd2183;
			6'd25:   c = -18'sd2893;
			6'd26:   c = -18'sd1957;
			6'd27:   c = -18'sd743;
			6'd28:   c = -18'sd33;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/sif_ram.sv */
`default_nettype none

module sif_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sif_ctrl.sv */
`default_nettype none

module sif_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output sif_pkg::sif_cmd_t         cmd,
	input  wire sif_pkg::sif_status_t st
);

	import sif_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DRAIN,
		PUSH
	} state_t;

	state_t           state_q;
	logic             ready_q;
	logic [TAP_W-1:0] tap_q;

	assign s_tready = ready_q;

	always_comb begin
		cmd.accept   = s_tvalid && ready_q;
		cmd.rd_en    = (state_q == RUN);
		cmd.tap      = tap_q;
		cmd.out_load = (state_q == PUSH) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b1;
			tap_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (s_tvalid && ready_q) begin
						ready_q <= 1'b0;
						tap_q   <= '0;
						state_q <= RUN;
					end
				end
				RUN: begin
					if (tap_q == TAP_W'(TAPS - 1)) begin
						state_q <= DRAIN;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				DRAIN: begin
					if (!st.pipe_busy) begin
						state_q <= PUSH;
					end
				end
				PUSH: begin
					if (st.out_free) begin
						ready_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: begin
					ready_q <= 1'b1;
					state_q <= IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_first_tap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (cmd.rd_en && tap_q == '0))
		else $error("tap sweep did not start after accept");

	a_no_read_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !s_tready)
		else $error("tap read while accepting");

	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!st.pipe_busy && st.out_free))
		else $error("result loaded before pipeline drained or output free");

	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> s_tready)
		else $error("not ready after result load");
`endif

endmodule

`default_nettype wire

/* rtl/core/sif_dp.sv */
`default_nettype none

module sif_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sif_pkg::sif_cmd_t         cmd,
	output sif_pkg::sif_status_t           st,
	input  wire logic [sif_pkg::SAMPLE_W-1:0] sample_in,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [sif_pkg::SAMPLE_W-1:0] sample_out
);

	import sif_pkg::*;

	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - 1;
	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(2 ** (FRAC_BITS - 1));

	logic [PTR_W-1:0]   wp_q;
	logic [FILL_W-1:0]  fill_q;
	logic [PTR_W-1:0]   rd_addr_q;
	logic [BACK_W-1:0]  back_q;

	logic [SAMPLE_W-1:0]        rd_data;
	logic                       valid_s1;
	logic                       live_s1;
	logic signed [COEF_W-1:0]   coef_s1;
	logic                       valid_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        out_q;

	logic signed [SAMPLE_W-1:0] tap_data;
	logic signed [ACC_W-1:0]    rounded;
	logic signed [ACC_W-1:0]    scaled;
	logic [SAMPLE_W-1:0]        sat_val;

	sif_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (wp_q),
		.wdata (sample_in),
		.re    (cmd.rd_en),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	// pointer and fill count, fill count stands in for clearing the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != FILL_W'(DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tap_data = live_s1 ? signed'(rd_data) : '0;
	assign rounded  = acc_q + HALF;
	assign scaled   = rounded >>> FRAC_BITS;

	always_comb begin
		if (scaled > OUT_MAX) begin
			sat_val = OUT_MAX[SAMPLE_W-1:0];
		end else if (scaled < OUT_MIN) begin
			sat_val = OUT_MIN[SAMPLE_W-1:0];
		end else begin
			sat_val = scaled[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_addr_q <= wp_q;
			back_q    <= '0;
		end else if (cmd.rd_en) begin
			rd_addr_q <= (rd_addr_q >= PTR_W'(SPACING)) ? rd_addr_q - PTR_W'(SPACING)
				: rd_addr_q + PTR_W'(DEPTH - SPACING);
			back_q    <= back_q + BACK_W'(SPACING);
		end
		if (cmd.rd_en) begin
			live_s1 <= (back_q < BACK_W'(fill_q));
			coef_s1 <= coef_lookup(COEF_IDX_W'(cmd.tap));
		end
		prod_s2 <= coef_s1 * tap_data;
		if (cmd.accept) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.out_load) begin
			out_q <= sat_val;
		end
	end

	assign st.pipe_busy = valid_s1 || valid_s2;
	assign st.out_free  = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign sample_out   = out_q;

endmodule

`default_nettype wire

/* rtl/core/sparse_interpolated_fir.sv */
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[15:0] sample_in
// m_*       out  m_tvalid/m_tready  m_tdata[15:0] sample_out
//
// each result comes from the single multiply-accumulate stepping through the taps
// on the store read port
// s_tready is low from accept until the result enters the output register
// a waiting result does not block the next accept
// reset clears pointer, fill count and handshakes; no clearing pass is needed
`default_nettype none

module sparse_interpolated_fir (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // sample_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata    // sample_out
);

	import sif_pkg::*;

	sif_cmd_t    cmd;
	sif_status_t st;

	sif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	sif_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.sample_in  (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.sample_out (m_tdata)
	);

endmodule

`default_nettype wire
